@@ sv/rv32_pkg.sv @@
`timescale 1ns / 1ps
package rv32_pkg;

  typedef enum logic [6:0] {
    OP_ILLEGAL = 7'd0, OP_ECALL = 7'd1, OP_EBREAK = 7'd2, OP_ADD = 7'd3,
    OP_SUB = 7'd4, OP_SLL = 7'd5, OP_SLT = 7'd6, OP_SLTU = 7'd7,
    OP_XOR = 7'd8, OP_SRL = 7'd9, OP_SRA = 7'd10, OP_OR = 7'd11,
    OP_AND = 7'd12, OP_SLLI = 7'd13, OP_SRLI = 7'd14, OP_SRAI = 7'd15,
    OP_BEQ = 7'd16, OP_BNE = 7'd17, OP_BLT = 7'd18, OP_BGE = 7'd19,
    OP_BLTU = 7'd20, OP_BGEU = 7'd21, OP_JALR = 7'd22, OP_ADDI = 7'd23,
    OP_SLTI = 7'd24, OP_SLTIU = 7'd25, OP_XORI = 7'd26, OP_ORI = 7'd27,
    OP_ANDI = 7'd28, OP_LB = 7'd29, OP_LH = 7'd30, OP_LW = 7'd31,
    OP_LBU = 7'd32, OP_LHU = 7'd33, OP_SB = 7'd34, OP_SH = 7'd35,
    OP_SW = 7'd36, OP_FENCE = 7'd37, OP_JAL = 7'd38, OP_LUI = 7'd39,
    OP_AUIPC = 7'd40, OP_CALL = 7'd41, OP_J = 7'd42, OP_LI = 7'd43,
    OP_MV = 7'd44
  } opcode_t;

  localparam logic [1:0] CAUSE_RUN = 2'd0;
  localparam logic [1:0] CAUSE_EXIT = 2'd1;
  localparam logic [1:0] CAUSE_BREAK = 2'd2;
  localparam logic [1:0] CAUSE_ILLEGAL = 2'd3;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_PRINT = 2'd1;
  localparam logic [1:0] EV_EXIT = 2'd2;

  localparam int QDEPTH = 2;

  // decoded request handed from front to back
  typedef struct packed {
    opcode_t     op;
    logic        legal;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] boff;
    logic [31:0] joff;
    logic [31:0] uimm;
  } dec_t;

  // result item
  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic [1:0]  halt_cause;
    logic [1:0]  sys_event;
    logic [31:0] sys_arg1;
    logic [31:0] sys_arg2;
  } res_t;

endpackage

@@ sv/rv32i_style_instruction_executor.sv @@
`timescale 1ns / 1ps
// Executes one instruction per request: a decode front classifies each word
// into a two-entry queue and the execute back retires it against the register
// file and byte memory, writing a one-deep result register. A result is ready
// in the cycle after the back takes its request; most instructions retire one
// per cycle while the result register is free, and loads first wait for the
// registered data memory read. Byte memory has no reset and MEM_BYTES must be
// a power of two of at least 16, since addresses wrap by dropping high bits.
module rv32i_style_instruction_executor #(
  parameter int MEM_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_instr_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_next_pc,
  output logic        out_halted,
  output logic [1:0]  out_halt_cause,
  output logic [1:0]  out_sys_event,
  output logic [31:0] out_sys_arg1,
  output logic [31:0] out_sys_arg2
);
  import rv32_pkg::*;

  dec_t dq;
  logic dv, dt, rv;
  res_t r;

  rv32_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_instr_word(in_instr_word), .dec_out(dq), .dec_valid(dv), .dec_take(dt)
  );

  rv32_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .dec_in(dq), .dec_valid(dv), .dec_take(dt),
    .res_out(r), .res_valid(rv), .res_take(out_pop)
  );

  assign out_empty      = !rv;
  assign out_next_pc    = r.next_pc;
  assign out_halted     = r.halted;
  assign out_halt_cause = r.halt_cause;
  assign out_sys_event  = r.sys_event;
  assign out_sys_arg1   = r.sys_arg1;
  assign out_sys_arg2   = r.sys_arg2;
endmodule

@@ sv/rv32_front.sv @@
`timescale 1ns / 1ps
module rv32_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [31:0]      in_instr_word,
  output rv32_pkg::dec_t   dec_out,
  output logic             dec_valid,
  input  logic             dec_take
);
  import rv32_pkg::*;

  dec_t         q_r [QDEPTH];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r, cnt_nxt;
  dec_t         d;
  logic         push_ok;

  // classify instruction fields
  always_comb begin
    d.op    = opcode_t'(in_instr_word[6:0]);
    d.legal = (in_instr_word[6:0] <= 7'd44) && (in_instr_word[6:0] != 7'd0);
    d.rd    = in_instr_word[11:7];
    d.rs1   = in_instr_word[16:12];
    d.rs2   = in_instr_word[21:17];
    d.imm   = {{20{in_instr_word[31]}}, in_instr_word[31:20]};
    d.boff  = {{19{in_instr_word[31]}}, in_instr_word[31:20], 1'b0};
    d.joff  = {{11{in_instr_word[31]}}, in_instr_word[31:12], 1'b0};
    d.uimm  = {in_instr_word[31:12], 12'd0};
  end

  assign in_full   = (cnt_r == 2'(QDEPTH));
  assign push_ok   = in_push && !in_full;
  assign dec_valid = (cnt_r != 2'd0);
  assign dec_out   = q_r[rp_r];

  // small queue between front and back
  always_comb begin
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(dec_take && dec_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wp_r <= ~wp_r;
      if (dec_take && dec_valid) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= d;
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDEPTH)) else $error("queue overflow");
  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !dec_valid) else $error("valid while empty");
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !dec_take) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("count did not grow");
endmodule

@@ sv/rv32_back.sv @@
`timescale 1ns / 1ps
module rv32_back #(
  parameter int MEM_BYTES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rv32_pkg::dec_t   dec_in,
  input  logic             dec_valid,
  output logic             dec_take,
  output rv32_pkg::res_t   res_out,
  output logic             res_valid,
  input  logic             res_take
);
  import rv32_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int BW = AW - 2;
  localparam int BDEPTH = MEM_BYTES / 4;

  logic [31:0]  rf_r [32];
  logic [7:0]   bank_r [4][BDEPTH];
  logic [7:0]   rdat_r [4];
  logic         ldw_r;
  logic [31:0]  pc_r, pc_nxt;
  logic         stop_r, stop_nxt;
  logic [1:0]   cause_r, cause_nxt;
  res_t         out_r, res;
  logic         ov_r;
  logic         fire;

  logic [31:0]  a, b, d, rv, npc, addr;
  logic         wr, take;
  logic [1:0]   ev;
  logic [31:0]  arg1, arg2;
  logic         is_load, is_store, ld_hold, st_go;
  logic [1:0]   kk [4];
  logic [31:0]  baddr [4];
  logic [BW-1:0] bix [4];
  logic         bwe [4];
  logic [7:0]   bwd [4];
  logic [31:0]  ld;

  // loads wait on the registered memory read before they are taken
  assign is_load   = dec_in.legal && (dec_in.op inside {[OP_LB:OP_LHU]});
  assign is_store  = dec_in.legal && (dec_in.op inside {OP_SB, OP_SH, OP_SW});
  assign ld_hold   = is_load && !stop_r && !ldw_r;

  // output register frees when taken
  assign dec_take  = !ld_hold && (!ov_r || res_take);
  assign fire      = dec_valid && dec_take;
  assign res_valid = ov_r;
  assign res_out   = out_r;
  assign st_go     = fire && !stop_r && is_store;

  assign a = rf_r[dec_in.rs1];
  assign b = rf_r[dec_in.rs2];
  assign d = rf_r[dec_in.rd];

  // byte banks by low address bits, wrap through the index width
  always_comb begin
    addr = is_store ? d + dec_in.imm : a + dec_in.imm;
    for (int j = 0; j < 4; j++) begin
      kk[j]    = 2'(j) - addr[1:0];
      baddr[j] = addr + {30'd0, kk[j]};
      bix[j]   = baddr[j][AW-1:2];
      bwe[j]   = st_go && (dec_in.op == OP_SW || kk[j] == 2'd0 ||
                 (dec_in.op == OP_SH && kk[j] == 2'd1));
      bwd[j]   = 8'(a >> {kk[j], 3'b000});
      ld[8*j +: 8] = rdat_r[2'(addr[1:0] + 2'(j))];
    end
  end

  // execute
  always_comb begin
    rv = 32'd0; wr = 1'b0; take = 1'b0; ev = EV_NONE;
    arg1 = 32'd0; arg2 = 32'd0;
    npc = pc_r + 32'd4;
    stop_nxt = stop_r; cause_nxt = cause_r;
    if (!dec_in.legal) begin
      stop_nxt = 1'b1; cause_nxt = CAUSE_ILLEGAL;
    end else begin
      case (dec_in.op)
        OP_ECALL: begin
          if (rf_r[10] == 32'd0) begin
            ev = EV_EXIT; arg1 = rf_r[11];
            stop_nxt = 1'b1; cause_nxt = CAUSE_EXIT;
          end else if (rf_r[10] == 32'd1) begin
            ev = EV_PRINT; arg1 = rf_r[11]; arg2 = rf_r[12];
          end else begin
            stop_nxt = 1'b1; cause_nxt = CAUSE_ILLEGAL;
          end
        end
        OP_EBREAK: begin stop_nxt = 1'b1; cause_nxt = CAUSE_BREAK; end
        OP_ADD:  begin rv = a + b; wr = 1'b1; end
        OP_SUB:  begin rv = a - b; wr = 1'b1; end
        OP_SLL:  begin rv = a << b[4:0]; wr = 1'b1; end
        OP_SLT:  begin rv = 32'($signed(a) < $signed(b)); wr = 1'b1; end
        OP_SLTU: begin rv = 32'(a < b); wr = 1'b1; end
        OP_XOR:  begin rv = a ^ b; wr = 1'b1; end
        OP_SRL:  begin rv = a >> b[4:0]; wr = 1'b1; end
        OP_SRA:  begin rv = 32'($signed(a) >>> b[4:0]); wr = 1'b1; end
        OP_OR:   begin rv = a | b; wr = 1'b1; end
        OP_AND:  begin rv = a & b; wr = 1'b1; end
        OP_SLLI: begin rv = a << dec_in.rs2; wr = 1'b1; end
        OP_SRLI: begin rv = a >> dec_in.rs2; wr = 1'b1; end
        OP_SRAI: begin rv = 32'($signed(a) >>> dec_in.rs2); wr = 1'b1; end
        OP_BEQ:  take = (d == a);
        OP_BNE:  take = (d != a);
        OP_BLT:  take = ($signed(d) < $signed(a));
        OP_BGE:  take = !($signed(d) < $signed(a));
        OP_BLTU: take = (d < a);
        OP_BGEU: take = (d >= a);
        OP_JALR: begin rv = npc; wr = 1'b1; npc = a + dec_in.boff; end
        OP_ADDI: begin rv = a + dec_in.imm; wr = 1'b1; end
        OP_SLTI: begin rv = 32'($signed(a) < $signed(dec_in.imm)); wr = 1'b1; end
        OP_SLTIU: begin rv = 32'(a < dec_in.imm); wr = 1'b1; end
        OP_XORI: begin rv = a ^ dec_in.imm; wr = 1'b1; end
        OP_ORI:  begin rv = a | dec_in.imm; wr = 1'b1; end
        OP_ANDI: begin rv = a & dec_in.imm; wr = 1'b1; end
        OP_LB:   begin rv = {{24{ld[7]}}, ld[7:0]}; wr = 1'b1; end
        OP_LH:   begin rv = {{16{ld[15]}}, ld[15:0]}; wr = 1'b1; end
        OP_LW:   begin rv = ld; wr = 1'b1; end
        OP_LBU:  begin rv = {24'd0, ld[7:0]}; wr = 1'b1; end
        OP_LHU:  begin rv = {16'd0, ld[15:0]}; wr = 1'b1; end
        OP_JAL:  begin rv = npc; wr = 1'b1; npc = pc_r + dec_in.joff; end
        OP_LUI:  begin rv = dec_in.uimm; wr = 1'b1; end
        OP_AUIPC: begin rv = pc_r + dec_in.uimm; wr = 1'b1; end
        OP_CALL: begin rv = npc; wr = 1'b1; npc = pc_r + dec_in.joff; end
        OP_J:    npc = pc_r + dec_in.joff;
        OP_LI:   begin rv = dec_in.imm; wr = 1'b1; end
        OP_MV:   begin rv = a; wr = 1'b1; end
        default: ;
      endcase
    end
    if (take) npc = pc_r + dec_in.boff;
    pc_nxt = npc;
    res.next_pc    = npc;
    res.halted     = stop_nxt;
    res.halt_cause = stop_nxt ? cause_nxt : CAUSE_RUN;
    res.sys_event  = ev;
    res.sys_arg1   = arg1;
    res.sys_arg2   = arg2;
    if (stop_r) begin
      res.next_pc = pc_r; res.halted = 1'b1; res.halt_cause = cause_r;
      res.sys_event = EV_NONE; res.sys_arg1 = 32'd0; res.sys_arg2 = 32'd0;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 32'd0; stop_r <= 1'b0; cause_r <= CAUSE_RUN; ov_r <= 1'b0;
      ldw_r <= 1'b0;
      for (int i = 0; i < 32; i++) rf_r[i] <= 32'd0;
    end else begin
      if (fire) ov_r <= 1'b1;
      else if (res_take) ov_r <= 1'b0;
      if (fire) ldw_r <= 1'b0;
      else if (dec_valid && ld_hold) ldw_r <= 1'b1;
      if (fire && !stop_r) begin
        pc_r <= pc_nxt; stop_r <= stop_nxt; cause_r <= cause_nxt;
        if (wr && dec_in.op == OP_CALL) rf_r[1] <= rv;
        else if (wr && dec_in.rd != 5'd0) rf_r[dec_in.rd] <= rv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_r <= res;
  end

  // byte-bank data memory with registered read
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      if (bwe[j]) bank_r[j][bix[j]] <= bwd[j];
      if (dec_valid && ld_hold) rdat_r[j] <= bank_r[j][bix[j]];
    end
  end

  a_x0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rf_r[0] == 32'd0) else $error("x0 written");
  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r && $stable(pc_r)) else $error("halted core moved");
  a_halt_cause: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> (cause_r != CAUSE_RUN)) else $error("halt without cause");
  a_load_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ldw_r |-> dec_valid) else $error("load wait without request");
endmodule
